### sv/vfa_pkg.sv
// vfa_pkg: shared types, widths and helpers for the fixed-point vector ALU.
// No dependencies; imported by every vfa_* module and the top level.

package vfa_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int WORD_W        = 32;
  localparam int OPND_W        = 33;   // operand of a lane multiplier (b - a needs 33 bits)
  localparam int PROD_W        = 66;
  localparam int ACC_W         = 68;   // three products summed, with headroom
  localparam int RAD_W         = 64;
  localparam int ROOT_W        = 32;
  localparam int SQ_STAGES     = RAD_W / 2;
  localparam int DEN_W         = 32;

  localparam logic signed [ACC_W-1:0] ACC_MAX = 68'sh0_7FFF_FFFF;
  localparam logic signed [ACC_W-1:0] ACC_MIN = -68'sh0_8000_0000;
  localparam logic [WORD_W-1:0]       W_MAX   = 32'h7FFF_FFFF;
  localparam logic [WORD_W-1:0]       W_MIN   = 32'h8000_0000;

  typedef enum logic [3:0] {
    OP_ADD   = 4'd0,
    OP_SUB   = 4'd1,
    OP_SCALE = 4'd2,
    OP_DIV   = 4'd3,
    OP_NEG   = 4'd4,
    OP_DOT   = 4'd5,
    OP_CROSS = 4'd6,
    OP_MAG   = 4'd7,
    OP_DIST  = 4'd8,
    OP_NORM  = 4'd9
  } op_e;

  typedef struct packed {
    logic [WORD_W-1:0] v;
    logic              ov;
  } sat_t;

  // carried alongside the square root pipeline
  typedef struct packed {
    op_e                    op;
    logic [2:0][WORD_W-1:0] res;
    logic [WORD_W-1:0]      sc;
    logic                   ov;
    logic                   big;
    logic [2:0][WORD_W-1:0] a;
    logic [WORD_W-1:0]      s;
  } sq_t;

  // carried alongside the divider pipeline
  typedef struct packed {
    op_e                    op;
    logic [2:0][WORD_W-1:0] res;
    logic [WORD_W-1:0]      sc;
    logic                   ov;
    logic                   dz;
    logic [2:0]             neg;
  } dv_t;

  typedef struct packed {
    logic [WORD_W-1:0] x;
    logic [WORD_W-1:0] y;
    logic [WORD_W-1:0] z;
    logic [WORD_W-1:0] sc;
    logic              ov;
    logic              dz;
  } res_t;

  function automatic sat_t sat_word(input logic signed [ACC_W-1:0] v);
    sat_t r;
    r.ov = 1'b0;
    r.v  = v[WORD_W-1:0];
    if (v > ACC_MAX) begin
      r.ov = 1'b1;
      r.v  = W_MAX;
    end else if (v < ACC_MIN) begin
      r.ov = 1'b1;
      r.v  = W_MIN;
    end
    return r;
  endfunction

endpackage

### sv/vfa_mul_lane.sv
// vfa_mul_lane: one component lane; picks multiplier operands by opcode, forms
// up to two full-width products and the add/sub/negate result. Uses vfa_pkg.

module vfa_mul_lane import vfa_pkg::*; (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  op_e                      op_i,
  input  logic signed [WORD_W-1:0] a_i,
  input  logic signed [WORD_W-1:0] b_i,
  input  logic signed [WORD_W-1:0] s_i,
  input  logic signed [WORD_W-1:0] x0_i,
  input  logic signed [WORD_W-1:0] y0_i,
  input  logic signed [WORD_W-1:0] x1_i,
  input  logic signed [WORD_W-1:0] y1_i,
  output logic signed [PROD_W-1:0] p0_o,
  output logic signed [PROD_W-1:0] p1_o,
  output logic signed [OPND_W-1:0] simple_o,
  output logic                     big_o
);

  localparam logic signed [OPND_W-1:0] D_LIM = 33'sh0_7FFF_FFFF;

  logic signed [OPND_W-1:0] ae, be, d;
  logic signed [OPND_W-1:0] m0a, m0b, m1a, m1b;
  logic signed [OPND_W-1:0] simple_d;
  logic signed [PROD_W-1:0] p0_q, p1_q;
  logic signed [OPND_W-1:0] simple_q;
  logic                     big_q;

  assign ae = OPND_W'(a_i);
  assign be = OPND_W'(b_i);
  assign d  = be - ae;

  always_comb begin
    m0a      = '0;
    m0b      = '0;
    m1a      = '0;
    m1b      = '0;
    simple_d = '0;
    unique case (op_i)
      OP_ADD:   simple_d = ae + be;
      OP_SUB:   simple_d = ae - be;
      OP_NEG:   simple_d = -ae;
      OP_SCALE: begin
        m0a = ae;
        m0b = OPND_W'(s_i);
      end
      OP_DOT: begin
        m0a = ae;
        m0b = be;
      end
      OP_CROSS: begin
        m0a = OPND_W'(x0_i);
        m0b = OPND_W'(y0_i);
        m1a = OPND_W'(x1_i);
        m1b = OPND_W'(y1_i);
      end
      OP_MAG, OP_NORM: begin
        m0a = ae;
        m0b = ae;
      end
      OP_DIST: begin
        m0a = d;
        m0b = d;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p0_q     <= m0a * m0b;
      p1_q     <= m1a * m1b;
      simple_q <= simple_d;
      big_q    <= (d > D_LIM) || (d < -D_LIM);
    end
  end

  assign p0_o     = p0_q;
  assign p1_o     = p1_q;
  assign simple_o = simple_q;
  assign big_o    = big_q;

endmodule

### sv/vfa_sqrt.sv
// vfa_sqrt: pipelined floor square root, one root bit per stage.
// 64-bit radicand, 32-bit root, SQ_STAGES register stages. Uses vfa_pkg.

module vfa_sqrt import vfa_pkg::*; (
  input  logic              clk_i,
  input  logic              en_i,
  input  logic [RAD_W-1:0]  rad_i,
  output logic [ROOT_W-1:0] root_o
);

  localparam int REM_W = ROOT_W + 4;

  logic [REM_W-1:0]  rem_q  [SQ_STAGES];
  logic [ROOT_W-1:0] root_q [SQ_STAGES];
  logic [RAD_W-1:0]  rad_q  [SQ_STAGES];
  logic [REM_W-1:0]  rem_in [SQ_STAGES];
  logic [ROOT_W-1:0] root_in[SQ_STAGES];
  logic [RAD_W-1:0]  rad_in [SQ_STAGES];
  logic [REM_W-1:0]  rem_d  [SQ_STAGES];
  logic [ROOT_W-1:0] root_d [SQ_STAGES];
  logic [RAD_W-1:0]  rad_d  [SQ_STAGES];

  always_comb begin
    logic [REM_W-1:0] rem_t;
    logic [REM_W-1:0] trial;
    rem_in[0]  = '0;
    root_in[0] = '0;
    rad_in[0]  = rad_i;
    for (int k = 1; k < SQ_STAGES; k++) begin
      rem_in[k]  = rem_q[k-1];
      root_in[k] = root_q[k-1];
      rad_in[k]  = rad_q[k-1];
    end
    for (int k = 0; k < SQ_STAGES; k++) begin
      rem_t = {rem_in[k][REM_W-3:0], rad_in[k][RAD_W-1 -: 2]};
      trial = REM_W'({root_in[k], 2'b01});
      if (rem_t >= trial) begin
        rem_d[k]  = rem_t - trial;
        root_d[k] = {root_in[k][ROOT_W-2:0], 1'b1};
      end else begin
        rem_d[k]  = rem_t;
        root_d[k] = {root_in[k][ROOT_W-2:0], 1'b0};
      end
      rad_d[k] = {rad_in[k][RAD_W-3:0], 2'b00};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < SQ_STAGES; k++) begin
        rem_q[k]  <= rem_d[k];
        root_q[k] <= root_d[k];
        rad_q[k]  <= rad_d[k];
      end
    end
  end

  assign root_o = root_q[SQ_STAGES-1];

endmodule

### sv/vfa_div.sv
// vfa_div: pipelined unsigned restoring divider, one quotient bit per stage.
// NUM_W-bit dividend, DEN_W-bit divisor, NUM_W stages. Uses vfa_pkg.

module vfa_div import vfa_pkg::*; #(
  parameter int NUM_W = WORD_W + FRAC_BITS_DEF
) (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic [NUM_W-1:0] quo_o
);

  // nq holds the unused dividend bits on top and the quotient bits below
  logic [DEN_W-1:0] rem_q [NUM_W];
  logic [NUM_W-1:0] nq_q  [NUM_W];
  logic [DEN_W-1:0] den_q [NUM_W];
  logic [DEN_W-1:0] rem_in[NUM_W];
  logic [NUM_W-1:0] nq_in [NUM_W];
  logic [DEN_W-1:0] den_in[NUM_W];
  logic [DEN_W-1:0] rem_d [NUM_W];
  logic [NUM_W-1:0] nq_d  [NUM_W];

  always_comb begin
    logic [DEN_W:0] tmp;
    logic           ge;
    rem_in[0] = '0;
    nq_in[0]  = num_i;
    den_in[0] = den_i;
    for (int k = 1; k < NUM_W; k++) begin
      rem_in[k] = rem_q[k-1];
      nq_in[k]  = nq_q[k-1];
      den_in[k] = den_q[k-1];
    end
    for (int k = 0; k < NUM_W; k++) begin
      tmp      = {rem_in[k], nq_in[k][NUM_W-1]};
      ge       = tmp >= {1'b0, den_in[k]};
      rem_d[k] = ge ? DEN_W'(tmp - {1'b0, den_in[k]}) : tmp[DEN_W-1:0];
      nq_d[k]  = {nq_in[k][NUM_W-2:0], ge};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < NUM_W; k++) begin
        rem_q[k] <= rem_d[k];
        nq_q[k]  <= nq_d[k];
        den_q[k] <= den_in[k];
      end
    end
  end

  assign quo_o = nq_q[NUM_W-1];

endmodule

### sv/vec3_fixed_point_alu.sv
// vec3_fixed_point_alu: three-component vector ALU in signed fixed point.
// Uses vfa_pkg, vfa_mul_lane, vfa_sqrt and vfa_div.
//
// Input beat: op_i, vectors a and b, scalar_in_i; taken when in_valid_i is
// high and in_stall_o is low. Output beat: one result per input beat, in
// order, held on the res_*_o ports while out_valid_o is high and out_stall_i
// is high.
// Every opcode runs through the same fixed pipeline: input register, three
// multiplier lanes, a merge stage, a 32-stage square root, a divisor set-up
// stage, a (32 + FRAC_BITS)-stage divider per lane and the output register.
// Throughput is one beat per cycle while in_stall_o is low.
// The whole pipeline moves while the skid register behind the output
// register is empty; a stalled output first fills the skid register, then
// in_stall_o goes high until the receiver takes a beat.
// Reset clears all valid bits; nothing is in flight afterwards.

module vec3_fixed_point_alu import vfa_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [3:0]        op_i,
  input  logic [WORD_W-1:0] ax_i,
  input  logic [WORD_W-1:0] ay_i,
  input  logic [WORD_W-1:0] az_i,
  input  logic [WORD_W-1:0] bx_i,
  input  logic [WORD_W-1:0] by_comp_i,
  input  logic [WORD_W-1:0] bz_i,
  input  logic [WORD_W-1:0] scalar_in_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [WORD_W-1:0] res_x_o,
  output logic [WORD_W-1:0] res_y_o,
  output logic [WORD_W-1:0] res_z_o,
  output logic [WORD_W-1:0] res_scalar_o,
  output logic              overflow_o,
  output logic              div_zero_o
);

  localparam int NW     = WORD_W + FRAC_BITS;
  localparam int PIPE_N = 3 + SQ_STAGES + 1 + NW;
  localparam logic [NW-1:0] Q_LIM = NW'(W_MIN);

  logic              adv;
  logic              accept;
  logic [PIPE_N-1:0] vld_q;

  // input register
  op_e                      op1_q;
  logic signed [WORD_W-1:0] a1_q [3];
  logic signed [WORD_W-1:0] b1_q [3];
  logic signed [WORD_W-1:0] s1_q;

  // lane stage
  op_e                      op2_q;
  logic signed [WORD_W-1:0] a2_q [3];
  logic signed [WORD_W-1:0] s2_q;
  logic signed [PROD_W-1:0] p0 [3];
  logic signed [PROD_W-1:0] p1 [3];
  logic signed [OPND_W-1:0] simple [3];
  logic [2:0]               big;

  // merge stage
  sq_t              sb3_d, sb3_q;
  logic [RAD_W-1:0] rad_d, rad_q;
  sq_t              sb_sq_q [SQ_STAGES];
  logic [ROOT_W-1:0] root;

  // divisor set-up
  dv_t              dv_d, dv_q;
  logic [DEN_W-1:0] den_d, den_q;
  logic [NW-1:0]    num_d [3];
  logic [NW-1:0]    num_q [3];
  dv_t              dv_dl_q [NW];
  logic [NW-1:0]    quo [3];

  // output
  res_t fin;
  res_t out_q, skid_q;
  logic out_vld_q, skid_vld_q;
  logic out_take, emerge;

  assign adv        = !skid_vld_q;
  assign in_stall_o = skid_vld_q;
  assign accept     = in_valid_i && !skid_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[PIPE_N-2:0], accept};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      op1_q   <= op_e'(op_i);
      a1_q[0] <= ax_i;
      a1_q[1] <= ay_i;
      a1_q[2] <= az_i;
      b1_q[0] <= bx_i;
      b1_q[1] <= by_comp_i;
      b1_q[2] <= bz_i;
      s1_q    <= scalar_in_i;
      op2_q   <= op1_q;
      a2_q    <= a1_q;
      s2_q    <= s1_q;
    end
  end

  // lane i forms a[i+1]*b[i+2] - a[i+2]*b[i+1] for the cross product
  for (genvar i = 0; i < 3; i++) begin : g_lane
    vfa_mul_lane u_lane (
      .clk_i    (clk_i),
      .en_i     (adv),
      .op_i     (op1_q),
      .a_i      (a1_q[i]),
      .b_i      (b1_q[i]),
      .s_i      (s1_q),
      .x0_i     (a1_q[(i+1)%3]),
      .y0_i     (b1_q[(i+2)%3]),
      .x1_i     (a1_q[(i+2)%3]),
      .y1_i     (b1_q[(i+1)%3]),
      .p0_o     (p0[i]),
      .p1_o     (p1[i]),
      .simple_o (simple[i]),
      .big_o    (big[i])
    );
  end

  // merge: saturate the simple ops, shift products, sum for dot and radicand
  always_comb begin
    logic signed [ACC_W-1:0] sum;
    logic signed [ACC_W-1:0] w;
    sat_t                    st;
    sum = ACC_W'(p0[0]) + ACC_W'(p0[1]) + ACC_W'(p0[2]);
    rad_d     = sum[RAD_W-1:0];
    sb3_d.op  = op2_q;
    sb3_d.res = '0;
    sb3_d.sc  = '0;
    sb3_d.ov  = 1'b0;
    sb3_d.big = |big;
    sb3_d.s   = s2_q;
    for (int i = 0; i < 3; i++) begin
      sb3_d.a[i] = a2_q[i];
    end
    for (int i = 0; i < 3; i++) begin
      unique case (op2_q)
        OP_ADD, OP_SUB, OP_NEG: w = ACC_W'(simple[i]);
        OP_SCALE:               w = ACC_W'(p0[i]) >>> FRAC_BITS;
        OP_CROSS:               w = (ACC_W'(p0[i]) - ACC_W'(p1[i])) >>> FRAC_BITS;
        default:                w = '0;
      endcase
      st            = sat_word(w);
      sb3_d.res[i]  = st.v;
      sb3_d.ov      = sb3_d.ov | st.ov;
    end
    if (op2_q == OP_DOT) begin
      st       = sat_word(sum >>> FRAC_BITS);
      sb3_d.sc = st.v;
      sb3_d.ov = st.ov;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sb3_q <= sb3_d;
      rad_q <= rad_d;
      sb_sq_q[0] <= sb3_q;
      for (int k = 1; k < SQ_STAGES; k++) begin
        sb_sq_q[k] <= sb_sq_q[k-1];
      end
    end
  end

  vfa_sqrt u_sqrt (
    .clk_i  (clk_i),
    .en_i   (adv),
    .rad_i  (rad_q),
    .root_o (root)
  );

  // divisor and dividend magnitudes, scalar results of magnitude and distance
  always_comb begin
    sq_t               sb;
    logic [WORD_W-1:0] aabs;
    logic [WORD_W-1:0] sabs;
    sb        = sb_sq_q[SQ_STAGES-1];
    dv_d.op   = sb.op;
    dv_d.res  = sb.res;
    dv_d.sc   = sb.sc;
    dv_d.ov   = sb.ov;
    dv_d.dz   = 1'b0;
    dv_d.neg  = '0;
    sabs      = sb.s[WORD_W-1] ? (~sb.s + 1'b1) : sb.s;
    den_d     = root;
    for (int i = 0; i < 3; i++) begin
      aabs     = sb.a[i][WORD_W-1] ? (~sb.a[i] + 1'b1) : sb.a[i];
      num_d[i] = NW'(aabs) << FRAC_BITS;
    end
    unique case (sb.op)
      OP_MAG: begin
        dv_d.sc = root[ROOT_W-1] ? W_MAX : root;
        dv_d.ov = root[ROOT_W-1];
      end
      OP_DIST: begin
        if (sb.big) begin
          dv_d.sc = W_MAX;
          dv_d.ov = 1'b1;
        end else begin
          dv_d.sc = root[ROOT_W-1] ? W_MAX : root;
          dv_d.ov = root[ROOT_W-1];
        end
      end
      OP_DIV: begin
        den_d   = sabs;
        dv_d.dz = (sb.s == '0);
        for (int i = 0; i < 3; i++) begin
          dv_d.neg[i] = sb.a[i][WORD_W-1] ^ sb.s[WORD_W-1];
        end
      end
      OP_NORM: begin
        dv_d.dz = (root == '0);
        for (int i = 0; i < 3; i++) begin
          dv_d.neg[i] = sb.a[i][WORD_W-1];
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      dv_q  <= dv_d;
      den_q <= den_d;
      num_q <= num_d;
      dv_dl_q[0] <= dv_q;
      for (int k = 1; k < NW; k++) begin
        dv_dl_q[k] <= dv_dl_q[k-1];
      end
    end
  end

  for (genvar i = 0; i < 3; i++) begin : g_div
    vfa_div #(
      .NUM_W (NW)
    ) u_div (
      .clk_i (clk_i),
      .en_i  (adv),
      .num_i (num_q[i]),
      .den_i (den_q),
      .quo_o (quo[i])
    );
  end

  // sign and saturate the quotients, pick the final fields
  always_comb begin
    dv_t               dv;
    logic [WORD_W-1:0] r [3];
    logic              ov;
    dv = dv_dl_q[NW-1];
    ov = dv.ov;
    for (int i = 0; i < 3; i++) begin
      r[i] = dv.res[i];
    end
    if ((dv.op == OP_DIV || dv.op == OP_NORM) && !dv.dz) begin
      for (int i = 0; i < 3; i++) begin
        if (dv.neg[i]) begin
          if (quo[i] > Q_LIM) begin
            r[i] = W_MIN;
            ov   = 1'b1;
          end else begin
            r[i] = ~quo[i][WORD_W-1:0] + 1'b1;
          end
        end else begin
          if (quo[i] >= Q_LIM) begin
            r[i] = W_MAX;
            ov   = 1'b1;
          end else begin
            r[i] = quo[i][WORD_W-1:0];
          end
        end
      end
    end
    fin.x  = r[0];
    fin.y  = r[1];
    fin.z  = r[2];
    fin.sc = dv.sc;
    fin.ov = ov;
    fin.dz = dv.dz;
  end

  assign out_take = out_vld_q && !out_stall_i;
  assign emerge   = adv && vld_q[PIPE_N-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else begin
      if (skid_vld_q) begin
        if (out_take) begin
          skid_vld_q <= 1'b0;
        end
      end else if (emerge) begin
        if (out_vld_q && !out_take) begin
          skid_vld_q <= 1'b1;
        end else begin
          out_vld_q <= 1'b1;
        end
      end else if (out_take) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_vld_q) begin
      if (out_take) begin
        out_q <= skid_q;
      end
    end else if (emerge) begin
      if (out_vld_q && !out_take) begin
        skid_q <= fin;
      end else begin
        out_q <= fin;
      end
    end
  end

  assign out_valid_o  = out_vld_q;
  assign res_x_o      = out_q.x;
  assign res_y_o      = out_q.y;
  assign res_z_o      = out_q.z;
  assign res_scalar_o = out_q.sc;
  assign overflow_o   = out_q.ov;
  assign div_zero_o   = out_q.dz;

endmodule
